// ----- rtl/positional_list_engine_macros.svh -----
// ---------------------------------------------------------------------------
// positional_list_engine_macros
// assertion helpers used by the checker file
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// same-cycle implication, held off during reset
`define PLE_ASSERT_SAME(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("ple assertion failed");

// next-cycle implication, held off during reset
`define PLE_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("ple assertion failed");

`endif

// ----- rtl/ple_pkg.sv -----
// ---------------------------------------------------------------------------
// ple_pkg
// shared types and constants of the positional list engine
// ---------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_W     = 32;
    localparam int CMD_W      = 3;
    localparam int POS_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int ENTRY_W    = 7;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (COUNT_W > POS_W) ? COUNT_W : POS_W;
    localparam int GROUP_SIZE = 8;
    localparam int GROUP_CNT  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [DATA_W-1:0] NO_VALUE = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 3'd0,
        CMD_HEAD   = 3'd1,
        CMD_TAIL   = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_DELETE = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [CMP_W-1:0]   pos;
    } cell_ctrl_t;

endpackage

// ----- rtl/ple_cell.sv -----
// ---------------------------------------------------------------------------
// ple_cell
// one list slot: holds, shifts from a neighbor or loads the new value
// ---------------------------------------------------------------------------
module ple_cell (
    input  logic                        aclk,
    input  ple_pkg::cell_ctrl_t         ctrl,
    input  logic [ple_pkg::CMP_W-1:0]   idx,
    input  logic [ple_pkg::DATA_W-1:0]  new_value,
    input  logic [ple_pkg::DATA_W-1:0]  left_value,
    input  logic [ple_pkg::DATA_W-1:0]  right_value,
    output logic [ple_pkg::DATA_W-1:0]  value,
    output logic [ple_pkg::DATA_W-1:0]  read_masked
);
    import ple_pkg::*;

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        unique case (ctrl.op)
            CELL_HOLD: begin
                value_next = value_reg;
            end
            CELL_INSERT: begin
                if (idx > ctrl.pos) begin
                    value_next = left_value;
                end else if (idx == ctrl.pos) begin
                    value_next = new_value;
                end
            end
            CELL_DELETE: begin
                if (idx >= ctrl.pos) begin
                    value_next = right_value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value       = value_reg;
    assign read_masked = (idx == ctrl.pos) ? value_reg : '0;

endmodule

// ----- rtl/ple_read_tree.sv -----
// ---------------------------------------------------------------------------
// ple_read_tree
// registered or-tree that picks the addressed cell value
// ---------------------------------------------------------------------------
module ple_read_tree (
    input  logic                                            aclk,
    input  logic                                            load,
    input  logic [ple_pkg::CAPACITY-1:0][ple_pkg::DATA_W-1:0] masked,
    output logic [ple_pkg::DATA_W-1:0]                      read_value
);
    import ple_pkg::*;

    logic [GROUP_CNT-1:0][DATA_W-1:0] group_reg;
    logic [GROUP_CNT-1:0][DATA_W-1:0] group_next;

    // first level: or within each group of cells
    always_comb begin
        group_next = '0;
        for (int g = 0; g < GROUP_CNT; g++) begin
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < CAPACITY) begin
                    group_next[g] = group_next[g] | masked[g * GROUP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            group_reg <= group_next;
        end
    end

    // second level: or across the group registers
    always_comb begin
        read_value = '0;
        for (int g = 0; g < GROUP_CNT; g++) begin
            read_value = read_value | group_reg[g];
        end
    end

endmodule

// ----- rtl/positional_list_engine.sv -----
// ---------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed values kept in a row of shifting cells
// ---------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_cmd, s_position, s_new_value
//  m_      | out       | m_valid / m_ready | m_read_value, m_status, m_entry_count
//
//  one transaction per cycle unless m_ stalls; each result moves through the
//  read stage and then the output register; every cell shifts, loads or holds
//  in the accept cycle, a get is read back through a two-level or-tree whose
//  first level is registered; aresetn clears the count and the stage valid
//  flags, cell contents are kept; a stall on m_ holds the output register and
//  then the read stage, after which s_ready drops
// ---------------------------------------------------------------------------
module positional_list_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ple_pkg::CMD_W-1:0]     s_cmd,
    input  logic [ple_pkg::POS_W-1:0]     s_position,
    input  logic signed [ple_pkg::DATA_W-1:0] s_new_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [ple_pkg::DATA_W-1:0] m_read_value,
    output logic [ple_pkg::STATUS_W-1:0]  m_status,
    output logic [ple_pkg::ENTRY_W-1:0]   m_entry_count
);
    import ple_pkg::*;

    // entry count
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    // read stage
    logic                st1_valid_reg;
    logic                st1_get_ok_reg;
    status_t             st1_status_reg;
    logic [COUNT_W-1:0]  st1_count_reg;

    // output register
    logic                m_valid_reg;
    logic [DATA_W-1:0]   m_read_value_reg;
    status_t             m_status_reg;
    logic [ENTRY_W-1:0]  m_entry_count_reg;

    logic                accept;
    logic                st1_adv;
    logic                full;
    logic                get_ok;
    status_t             status;
    cell_ctrl_t          ctrl;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    count_ext;
    logic [DATA_W-1:0]   tree_value;

    logic [CAPACITY-1:0][DATA_W-1:0] cell_value;
    logic [CAPACITY-1:0][DATA_W-1:0] cell_masked;

    // handshake: read stage moves on when the output register is free
    assign st1_adv = !m_valid_reg || m_ready;
    assign s_ready = !st1_valid_reg || st1_adv;
    assign accept  = s_valid && s_ready;

    assign pos_ext   = CMP_W'(s_position);
    assign count_ext = CMP_W'(count_reg);
    assign full      = (count_reg == COUNT_W'(CAPACITY));

    // command decode: cell operation, status and new count
    always_comb begin
        ctrl.op    = CELL_HOLD;
        ctrl.pos   = pos_ext;
        status     = ST_DONE;
        get_ok     = 1'b0;
        count_next = count_reg;
        unique case (cmd_t'(s_cmd))
            CMD_GET: begin
                if (pos_ext < count_ext) begin
                    get_ok = 1'b1;
                end else begin
                    status = ST_INVALID;
                end
            end
            CMD_HEAD: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.op    = CELL_INSERT;
                    ctrl.pos   = '0;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_TAIL: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.op    = CELL_INSERT;
                    ctrl.pos   = count_ext;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_INSERT: begin
                // position check comes ahead of the full check
                priority if (pos_ext > count_ext) begin
                    status = ST_INVALID;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.op    = CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_DELETE: begin
                // deleting at the count itself is out of range
                if (pos_ext < count_ext) begin
                    ctrl.op    = CELL_DELETE;
                    count_next = count_reg - 1'b1;
                end else begin
                    status = ST_INVALID;
                end
            end
            default: begin
                status = ST_INVALID;
            end
        endcase
        // cells only move on an accepted transaction
        if (!accept) begin
            ctrl.op = CELL_HOLD;
        end
    end

    // row of cells, position 0 at index 0
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_value;
        logic [DATA_W-1:0] right_value;

        if (i == 0) begin : g_first
            assign left_value = '0;
        end else begin : g_left
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_right
            assign right_value = cell_value[i+1];
        end

        ple_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .idx         (CMP_W'(i)),
            .new_value   (s_new_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .read_masked (cell_masked[i])
        );
    end

    // readback of the addressed cell
    ple_read_tree u_read_tree (
        .aclk       (aclk),
        .load       (accept),
        .masked     (cell_masked),
        .read_value (tree_value)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                st1_valid_reg <= 1'b1;
            end else if (st1_adv) begin
                st1_valid_reg <= 1'b0;
            end
            if (st1_adv) begin
                m_valid_reg <= st1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_get_ok_reg <= get_ok;
            st1_status_reg <= status;
            st1_count_reg  <= count_next;
        end
        if (st1_adv && st1_valid_reg) begin
            m_read_value_reg  <= st1_get_ok_reg ? tree_value : NO_VALUE;
            m_status_reg      <= st1_status_reg;
            m_entry_count_reg <= ENTRY_W'(st1_count_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;

endmodule

// ----- rtl/ple_checker.sv -----
// ---------------------------------------------------------------------------
// ple_checker
// port-level checks on the result channel of the list engine
// ---------------------------------------------------------------------------
`include "positional_list_engine_macros.svh"

module ple_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [ple_pkg::DATA_W-1:0]    m_read_value,
    input logic [ple_pkg::STATUS_W-1:0]  m_status,
    input logic [ple_pkg::ENTRY_W-1:0]   m_entry_count
);
    import ple_pkg::*;

    // refused or invalid transactions never carry a value
    `PLE_ASSERT_SAME(a_fail_no_value, aclk, aresetn, m_valid && m_status != ST_DONE, m_read_value == NO_VALUE)

    // only the three defined status codes appear
    `PLE_ASSERT_SAME(a_status_code, aclk, aresetn, m_valid, m_status == ST_DONE || m_status == ST_INVALID || m_status == ST_FULL)

    // a full refusal only happens at capacity
    `PLE_ASSERT_SAME(a_full_count, aclk, aresetn, m_valid && m_status == ST_FULL, m_entry_count == ENTRY_W'(CAPACITY))

    // a stalled result stays presented
    `PLE_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_value) && $stable(m_status))

endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_read_value  (m_read_value),
    .m_status      (m_status),
    .m_entry_count (m_entry_count)
);
